### hw/rtl/record_preserving_log_ring_assert.svh
// Assertion macros for the log ring RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef RECORD_PRESERVING_LOG_RING_ASSERT_SVH
`define RECORD_PRESERVING_LOG_RING_ASSERT_SVH
`ifndef SYNTHESIS
`define RPLR_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define RPLR_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition");
`else
`define RPLR_ASSERT_IMPL(label, clk, rst, prop)
`define RPLR_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

### hw/rtl/rplr_pkg.sv
// Shared types and constants for the record preserving log ring.
// No dependencies.
package rplr_pkg;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam int unsigned REG_CAPACITY = 0;
  localparam int unsigned REG_SINK = 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_READ  = 1'b1
  } mode_t;

  // one classified request passed from front to back
  typedef struct packed {
    logic        mode;
    logic [7:0]  data_byte;
    logic        record_start;
    logic [15:0] record_length;
    logic [6:0]  read_limit;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIT,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_PUT,
    ST_READ,
    ST_READ_WAIT
  } state_t;
endpackage

### hw/rtl/rplr_front.sv
// Front part: accepts requests and holds them in a short queue.
// Depends on rplr_pkg.
module rplr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rplr_pkg::req_t  req_in,
  output logic            busy,
  output logic            q_valid,
  output rplr_pkg::req_t  q_req,
  input  logic            q_pop
);
  rplr_pkg::req_t slots [rplr_pkg::QUEUE_DEPTH];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;

  assign busy    = (fill == 2'(rplr_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_req   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= req_in;
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end
endmodule

### hw/rtl/rplr_back.sv
// Back part: ring memory, record fit and drop sequencer, read drain.
// Depends on rplr_pkg and the assertion macro header.
`include "record_preserving_log_ring_assert.svh"
module rplr_back #(
  parameter int unsigned DEPTH    = 4096,
  parameter int unsigned MAX_READ = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  rplr_pkg::req_t  q_req,
  output logic            q_pop,
  input  logic            cfg_we,
  input  logic            cfg_sel,
  input  logic [12:0]     cfg_capacity,
  input  logic            cfg_sink,
  output logic            strobe,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            last_of_run,
  output logic [12:0]     stored_bytes
);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;
  logic [AW-1:0] raddr;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] waddr;

  rplr_pkg::state_t state, state_next;
  logic [CW-1:0] capacity;
  logic          sink;
  logic [AW-1:0] oldest;
  logic [CW-1:0] count;
  logic [15:0]   skip_left;
  logic [15:0]   rec_left;
  logic [15:0]   len_r;
  logic [CW-1:0] scan_i;
  logic [AW-1:0] scan_pos;
  logic [6:0]    rd_n;
  logic [6:0]    rd_k;
  logic [CW-1:0] cap_sat;

  // ring index helpers: values stay below twice capacity
  function automatic logic [AW-1:0] wrap(input logic [CW:0] v, input logic [CW-1:0] c);
    logic [CW:0] r;
    r = (v >= {1'b0, c}) ? v - {1'b0, c} : v;
    return r[AW-1:0];
  endfunction

  always_comb begin
    logic [13:0] v;
    v = {1'b0, cfg_capacity};
    if (v == 14'd0) v = 14'(DEPTH);
    if (v < 14'd2) v = 14'd2;
    if (v > 14'(DEPTH)) v = 14'(DEPTH);
    cap_sat = CW'(v);
  end

  logic [CW:0] need;
  assign need = {1'b0, count} + (CW+1)'(len_r);

  always_comb begin
    state_next = state;
    case (state)
      rplr_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (q_req.mode == rplr_pkg::MODE_READ) state_next = rplr_pkg::ST_READ;
          else if (sink && q_req.record_start && q_req.record_length != 16'd0)
            state_next = rplr_pkg::ST_FIT;
          else state_next = rplr_pkg::ST_PUT;
        end
      end
      rplr_pkg::ST_FIT: begin
        if (need > {1'b0, capacity}) state_next = rplr_pkg::ST_SCAN;
        else state_next = rplr_pkg::ST_PUT;
      end
      rplr_pkg::ST_SCAN: state_next = rplr_pkg::ST_SCAN_WAIT;
      rplr_pkg::ST_SCAN_WAIT: begin
        if (scan_i >= count) state_next = rplr_pkg::ST_FIT;
        else if (rdata == rplr_pkg::NEWLINE_CODE) state_next = rplr_pkg::ST_FIT;
        else state_next = rplr_pkg::ST_SCAN;
      end
      rplr_pkg::ST_PUT: state_next = rplr_pkg::ST_IDLE;
      rplr_pkg::ST_READ: begin
        if (rd_n == 7'd0) state_next = rplr_pkg::ST_IDLE;
        else state_next = rplr_pkg::ST_READ_WAIT;
      end
      rplr_pkg::ST_READ_WAIT: begin
        if (rd_k + 7'd1 >= rd_n) state_next = rplr_pkg::ST_IDLE;
        else state_next = rplr_pkg::ST_READ_WAIT;
      end
      default: state_next = rplr_pkg::ST_IDLE;
    endcase
  end

  logic [6:0] lim_sat;
  logic [6:0] n_calc;
  always_comb begin
    lim_sat = (q_req.read_limit > 7'(MAX_READ)) ? 7'(MAX_READ) : q_req.read_limit;
    if (CW'(lim_sat) <= count) n_calc = lim_sat;
    else n_calc = 7'(count);
  end

  // outputs and memory control
  always_comb begin
    strobe      = 1'b0;
    out_valid   = 1'b0;
    out_byte    = 8'd0;
    last_of_run = 1'b0;
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    raddr       = scan_pos;
    wr_en       = 1'b0;
    waddr       = wrap({1'b0, CW'(oldest)} + {1'b0, count}, capacity);
    case (state)
      rplr_pkg::ST_IDLE: begin
        // first read byte fetched as soon as the request shows up
        rd_en = 1'b1;
        raddr = oldest;
      end
      rplr_pkg::ST_SCAN: rd_en = 1'b1;
      rplr_pkg::ST_PUT: begin
        strobe = 1'b1;
        last_of_run = 1'b1;
        q_pop = 1'b1;
        wr_en = q_req.mode == rplr_pkg::MODE_WRITE && sink && skip_left == 16'd0 &&
                rec_left != 16'd0 && count < capacity;
      end
      rplr_pkg::ST_READ: begin
        if (rd_n == 7'd0) begin
          strobe = 1'b1;
          last_of_run = 1'b1;
          q_pop = 1'b1;
        end
      end
      rplr_pkg::ST_READ_WAIT: begin
        strobe = 1'b1;
        out_valid = 1'b1;
        out_byte = rdata;
        rd_en = 1'b1;
        raddr = wrap({1'b0, CW'(oldest)} + (CW+1)'(1), capacity);
        if (rd_k + 7'd1 >= rd_n) begin
          last_of_run = 1'b1;
          q_pop = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[waddr] <= q_req.data_byte;
    if (rd_en) rdata <= mem[raddr];
  end

  // count as it stands once this result's byte is drained or stored
  assign stored_bytes = 13'(count - CW'(out_valid) + CW'(wr_en));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rplr_pkg::ST_IDLE;
      capacity  <= CW'(DEPTH);
      sink      <= 1'b0;
      oldest    <= '0;
      count     <= '0;
      skip_left <= '0;
      rec_left  <= '0;
    end else begin
      state <= state_next;
      case (state)
        rplr_pkg::ST_IDLE: begin
          if (q_valid && q_req.mode == rplr_pkg::MODE_READ) begin
            rd_n <= n_calc;
            rd_k <= 7'd0;
          end else if (q_valid && sink && q_req.record_start) begin
            skip_left <= '0;
            rec_left  <= '0;
            if (q_req.record_length != 16'd0) begin
              if ({3'b0, q_req.record_length} >= 19'(capacity)) begin
                skip_left <= q_req.record_length - 16'(capacity - CW'(1));
                len_r     <= 16'(capacity - CW'(1));
                oldest    <= '0;
                count     <= '0;
              end else begin
                len_r <= q_req.record_length;
              end
            end
          end
        end
        rplr_pkg::ST_FIT: begin
          scan_i   <= '0;
          scan_pos <= oldest;
          if (!(need > {1'b0, capacity})) rec_left <= len_r;
        end
        rplr_pkg::ST_SCAN_WAIT: begin
          if (scan_i >= count) begin
            oldest <= '0;
            count  <= '0;
          end else if (rdata == rplr_pkg::NEWLINE_CODE) begin
            oldest <= wrap({1'b0, CW'(scan_pos)} + (CW+1)'(1), capacity);
            count  <= count - scan_i - CW'(1);
          end else begin
            scan_i   <= scan_i + CW'(1);
            scan_pos <= wrap({1'b0, CW'(scan_pos)} + (CW+1)'(1), capacity);
          end
        end
        rplr_pkg::ST_PUT: begin
          if (q_req.mode == rplr_pkg::MODE_WRITE && sink) begin
            if (skip_left != 16'd0) skip_left <= skip_left - 16'd1;
            else if (rec_left != 16'd0) begin
              rec_left <= rec_left - 16'd1;
              if (count < capacity) count <= count + CW'(1);
            end
          end
        end
        rplr_pkg::ST_READ_WAIT: begin
          oldest <= wrap({1'b0, CW'(oldest)} + (CW+1)'(1), capacity);
          count  <= count - CW'(1);
          rd_k   <= rd_k + 7'd1;
        end
        default: ;
      endcase
      if (cfg_we) begin
        if (cfg_sel) sink <= cfg_sink;
        else begin
          capacity  <= cap_sat;
          oldest    <= '0;
          count     <= '0;
          skip_left <= '0;
          rec_left  <= '0;
        end
      end
    end
  end

  `RPLR_ASSERT_NEVER(a_count_cap, clk, rst, count > capacity)
  `RPLR_ASSERT_IMPL(a_pop_strobe, clk, rst, q_pop |-> strobe && last_of_run)
  `RPLR_ASSERT_IMPL(a_valid_empty, clk, rst, out_valid |-> count != '0)
endmodule

### hw/rtl/record_preserving_log_ring.sv
// Top level of the record preserving log ring.
// Depends on rplr_pkg, rplr_front and rplr_back.
//
// Usage: pulse start with mode and its fields while busy is low; the request
// is queued (two entries) and busy rises only when the queue is full.
// A write request gives one strobe with out_valid low from the PUT state,
// reached through IDLE; the back part takes one request at a time.
// A record start adds a FIT step; when old records must be dropped it
// scans the ring byte by byte (SCAN, SCAN_WAIT) through the single memory
// read port, returning to FIT after each record dropped.
// A read request of n bytes passes IDLE and READ, then gives one strobe
// per cycle from READ_WAIT until its last byte; a read that drains
// nothing gives one strobe with out_valid low from READ.
// last_of_run marks the final strobe of a request; stored_bytes is the count
// after that result. Results cannot be held off by the receiver.
// Configuration: cfg_valid with cfg_index and cfg_data, always ready.
// Reset empties the ring, sets capacity to DEPTH and disables the sink;
// ring contents need no clearing.
module record_preserving_log_ring #(
  parameter int unsigned DEPTH    = 4096,
  parameter int unsigned MAX_READ = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [7:0]  data_byte,
  input  logic        record_start,
  input  logic [15:0] record_length,
  input  logic [6:0]  read_limit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  output logic        strobe,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic [12:0] stored_bytes
);
  rplr_pkg::req_t req_in;
  rplr_pkg::req_t q_req;
  logic q_valid;
  logic q_pop;

  assign req_in = '{mode: mode, data_byte: data_byte, record_start: record_start,
                    record_length: record_length, read_limit: read_limit};
  assign cfg_ready = 1'b1;

  rplr_front u_front (
    .clk(clk), .rst(rst), .start(start), .req_in(req_in), .busy(busy),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  rplr_back #(.DEPTH(DEPTH), .MAX_READ(MAX_READ)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .cfg_we(cfg_valid), .cfg_sel(cfg_index == 1'(rplr_pkg::REG_SINK)),
    .cfg_capacity(cfg_data), .cfg_sink(cfg_data[0]),
    .strobe(strobe), .out_valid(out_valid), .out_byte(out_byte),
    .last_of_run(last_of_run), .stored_bytes(stored_bytes)
  );
endmodule
